>>> sv/tmpt_pkg.sv
// Shared constants, types and saturating helpers for the Taylor map tracker.
// Used by the top level, tmpt_mul and tmpt_div; depends on nothing.
package tmpt_pkg;

    // Term table geometry
    localparam int MAX_TERMS = 1024;
    localparam int TERM_AW   = $clog2(MAX_TERMS);
    localparam int TERM_CW   = TERM_AW + 1;
    localparam logic [3:0] MAX_POWER = 4'd15;

    localparam int NUM_VARS = 9;
    localparam int NUM_SUMS = 15;

    // Q24.40 constants
    localparam logic [63:0] Q_ONE  = 64'h0000_0100_0000_0000;
    localparam logic [63:0] Q_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [127:0] Q_HALF_WIDE = 128'h8000000000;

    // Command codes
    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_WRITE  = 3'd2;
    localparam logic [2:0] CMD_START  = 3'd3;
    localparam logic [2:0] CMD_TRACK  = 3'd4;

    // Term target that feeds no sum, and the result index of the arrival time
    localparam logic [3:0] TGT_NONE  = 4'd15;
    localparam logic [3:0] IDX_TIME  = 4'd9;
    localparam logic [3:0] IDX_LASTV = 4'd8;

    // Configuration register indexes
    localparam logic [1:0] CFG_KOM = 2'd0;
    localparam logic [1:0] CFG_IBC = 2'd1;
    localparam logic [1:0] CFG_RP  = 2'd2;

    // One stored term
    typedef struct packed {
        logic [3:0]  target;
        logic [23:0] powers;
        logic [63:0] coef;
    } term_t;

    localparam int TERM_W = $bits(term_t);

    // Divide unit operation
    typedef enum logic {
        DIV_QUOT = 1'b0,
        DIV_ROOT = 1'b1
    } div_mode_t;

    // Request to the divide / root unit
    typedef struct packed {
        logic        start;
        div_mode_t   mode;
    } div_req_t;

    // Saturating add of two Q24.40 values
    function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) begin
            return Q_MAX;
        end else if (a[63] && b[63] && !s[63]) begin
            return Q_MIN;
        end
        return s;
    endfunction

    // Saturating negate
    function automatic logic [63:0] sneg(input logic [63:0] a);
        if (a == Q_MIN) begin
            return Q_MAX;
        end
        return (~a) + 64'd1;
    endfunction

    // Limit an exponent to the largest supported power
    function automatic logic [3:0] clamp_pow(input logic [3:0] p);
        return (p > MAX_POWER) ? MAX_POWER : p;
    endfunction

endpackage

>>> sv/taylor_map_particle_tracker.sv
// Taylor map particle tracker: top level with the command sequencer.
// Depends on tmpt_pkg, tmpt_ram, tmpt_mul and tmpt_div.
//
// Terms live in a 1024-entry RAM (one term read per cycle, registered read data);
// clear, append and variable writes each give one result item. A track walks
// the terms in table order: each term takes one product in the shared
// sequential multiplier (four 32x32 partial products a product) for every unit
// of its exponents, and a term aimed at no sum is skipped. The spin rotation
// then takes 12 products, the norm a root and three divides, the arrival time
// four products and one divide, and ten result items follow at one a cycle
// while the output is not stalled. A start runs only the arrival time and the
// ten result items. Input is taken only between commands, and only while the
// output register is empty or being emptied.
module taylor_map_particle_tracker (
    input  logic         aclk,
    input  logic         aresetn,
    // cfg port
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd, target, value, power_x, power_xp, power_y, power_yp, power_l,
    // power_dkk, var_index (from bit 0 up), zero fill
    input  logic [103:0] s_tdata,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_index, out_value, turn_number, error (from bit 0 up), zero fill
    output logic [87:0]  m_tdata,
    output logic         m_tlast
);
    import tmpt_pkg::*;

    typedef enum logic [17:0] {
        ST_IDLE  = 18'h00001,
        ST_T_RD  = 18'h00002,
        ST_T_LAT = 18'h00004,
        ST_T_POW = 18'h00008,
        ST_T_MW  = 18'h00010,
        ST_T_ACC = 18'h00020,
        ST_S_MUL = 18'h00040,
        ST_S_MW  = 18'h00080,
        ST_S_SQ  = 18'h00100,
        ST_S_SQW = 18'h00200,
        ST_S_CHK = 18'h00400,
        ST_S_RW  = 18'h00800,
        ST_S_DIV = 18'h01000,
        ST_S_DW  = 18'h02000,
        ST_COPY  = 18'h04000,
        ST_A_OP  = 18'h08000,
        ST_A_W   = 18'h10000,
        ST_EMIT  = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    // Input fields
    logic [2:0]  in_cmd;
    logic [3:0]  in_target;
    logic [63:0] in_value;
    logic [23:0] in_powers;
    logic [3:0]  in_vidx;
    logic        s_fire;

    assign in_cmd    = s_tdata[2:0];
    assign in_target = s_tdata[6:3];
    assign in_value  = s_tdata[70:7];
    assign in_powers = s_tdata[94:71];
    assign in_vidx   = s_tdata[98:95];

    // Registers
    logic [63:0]        kom_reg, ibc_reg, rp_reg;
    logic [TERM_CW-1:0] term_cnt_reg;
    logic [TERM_CW-1:0] t_reg;
    logic [15:0]        turn_reg;
    logic [63:0]        var_reg [NUM_VARS];
    logic [63:0]        acc_reg [NUM_SUMS];
    logic [63:0]        so_reg [3];
    logic [63:0]        so_acc_reg, sum_reg, norm_reg;
    logic [63:0]        r_reg, g_reg, lead_reg, time_reg;
    logic [23:0]        pow_reg;
    logic [3:0]         tg_reg;
    logic [2:0]         i_reg;
    logic [1:0]         j_reg;
    logic [3:0]         u_reg;
    logic [3:0]         k_reg;
    logic [2:0]         step_reg;
    logic               err_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [3:0]  out_idx_reg;
    logic [63:0] out_val_reg;
    logic [15:0] out_turn_reg;
    logic        out_err_reg;
    logic        out_last_reg;
    logic        out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_tvalid && s_tready;

    // Term RAM
    logic               ram_we, ram_re;
    logic [TERM_AW-1:0] ram_waddr, ram_raddr;
    term_t              ram_wdata, ram_rdata;

    tmpt_ram #(
        .WIDTH (TERM_W),
        .DEPTH (MAX_TERMS)
    ) u_term_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Arithmetic units
    logic        mul_start, mul_done;
    logic [63:0] mul_a, mul_b, mul_res;
    div_req_t    div_req;
    logic        div_done;
    logic [63:0] div_num, div_den, div_res;

    tmpt_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    tmpt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .result  (div_res)
    );

    // Read ports of the small register files
    logic [3:0]  var_ridx, acc_ridx;
    logic [1:0]  so_ridx;
    logic [63:0] var_rd, acc_rd, so_rd;
    logic [3:0]  cur_pow;

    always_comb begin
        var_ridx = 4'd0;
        acc_ridx = 4'd0;
        so_ridx  = j_reg;
        unique case (state_reg)
            ST_T_POW: var_ridx = {1'b0, i_reg};
            ST_S_MUL: begin
                var_ridx = 4'd6 + {2'b00, j_reg};
                acc_ridx = 4'd6 + ({1'b0, i_reg} * 4'd3) + {2'b00, j_reg};
            end
            ST_A_OP:  var_ridx = (step_reg == 3'd0) ? 4'd5 : 4'd4;
            ST_EMIT:  var_ridx = k_reg;
            ST_T_ACC: acc_ridx = tg_reg;
            ST_COPY: begin
                acc_ridx = k_reg;
                so_ridx  = 2'(k_reg - 4'd6);
            end
            ST_S_DIV: so_ridx = i_reg[1:0];
            default: ;
        endcase
        var_rd  = (var_ridx < 4'(NUM_VARS)) ? var_reg[var_ridx] : '0;
        acc_rd  = (acc_ridx < 4'(NUM_SUMS)) ? acc_reg[acc_ridx] : '0;
        so_rd   = (so_ridx != 2'd3) ? so_reg[so_ridx] : '0;
        cur_pow = pow_reg[{i_reg, 2'b00} +: 4];
    end

    // Unit requests
    always_comb begin
        mul_start    = 1'b0;
        mul_a        = r_reg;
        mul_b        = var_rd;
        div_req      = '{start: 1'b0, mode: DIV_QUOT};
        div_num      = so_rd;
        div_den      = norm_reg;
        unique case (state_reg)
            ST_T_POW: mul_start = (u_reg < cur_pow);
            ST_S_MUL: begin
                mul_start = 1'b1;
                mul_a     = acc_rd;
            end
            ST_S_SQ: begin
                mul_start = 1'b1;
                mul_a     = so_acc_reg;
                mul_b     = so_acc_reg;
            end
            ST_S_CHK: begin
                div_req.start = !(sum_reg[63] || sum_reg == '0);
                div_req.mode  = DIV_ROOT;
                div_num       = sum_reg;
            end
            ST_S_DIV: div_req.start = 1'b1;
            ST_A_OP: begin
                case (step_reg)
                    3'd0: begin
                        mul_start = 1'b1;
                        mul_a     = sadd(Q_ONE, var_rd);
                        mul_b     = kom_reg;
                    end
                    3'd1: begin
                        div_req.start = 1'b1;
                        div_num       = sadd(g_reg, Q_ONE);
                        div_den       = g_reg;
                    end
                    3'd2: begin
                        mul_start = 1'b1;
                        mul_a     = lead_reg;
                        mul_b     = ibc_reg;
                    end
                    3'd3: begin
                        mul_start = 1'b1;
                        mul_a     = lead_reg;
                    end
                    default: begin
                        mul_start = 1'b1;
                        mul_a     = {8'd0, turn_reg, 40'd0};
                        mul_b     = rp_reg;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // Append writes the term RAM, the walk reads it
    always_comb begin
        ram_we    = s_fire && in_cmd == CMD_APPEND && term_cnt_reg != TERM_CW'(MAX_TERMS);
        ram_waddr = term_cnt_reg[TERM_AW-1:0];
        ram_wdata = '{target: in_target,
                      powers: {clamp_pow(in_powers[23:20]), clamp_pow(in_powers[19:16]),
                               clamp_pow(in_powers[15:12]), clamp_pow(in_powers[11:8]),
                               clamp_pow(in_powers[7:4]), clamp_pow(in_powers[3:0])},
                      coef:   in_value};
        ram_re    = (state_reg == ST_T_RD) && (t_reg != term_cnt_reg);
        ram_raddr = t_reg[TERM_AW-1:0];
    end

    // Variable write port
    logic        var_we;
    logic [3:0]  var_widx;
    logic [63:0] var_wdata;

    always_comb begin
        var_we    = 1'b0;
        var_widx  = k_reg;
        var_wdata = (k_reg < 4'd6) ? acc_rd : so_rd;
        if (state_reg == ST_COPY) begin
            var_we = 1'b1;
        end else if (s_fire && in_cmd == CMD_WRITE && in_vidx <= IDX_LASTV) begin
            var_we    = 1'b1;
            var_widx  = in_vidx;
            var_wdata = in_value;
        end
    end

    // Output load
    logic        out_load;
    logic [3:0]  out_idx_d;
    logic [63:0] out_val_d;
    logic        out_err_d;
    logic        out_last_d;

    always_comb begin
        out_load   = 1'b0;
        out_idx_d  = 4'd0;
        out_val_d  = '0;
        out_err_d  = 1'b0;
        out_last_d = 1'b1;
        if (state_reg == ST_EMIT) begin
            out_load   = out_free;
            out_idx_d  = k_reg;
            out_val_d  = (k_reg == IDX_TIME) ? time_reg : var_rd;
            out_err_d  = err_reg;
            out_last_d = (k_reg == IDX_TIME);
        end else if (s_fire) begin
            unique case (in_cmd)
                CMD_CLEAR: out_load = 1'b1;
                CMD_APPEND: begin
                    out_load  = 1'b1;
                    out_err_d = (term_cnt_reg == TERM_CW'(MAX_TERMS));
                end
                CMD_WRITE: begin
                    out_load = 1'b1;
                    if (in_vidx <= IDX_LASTV) begin
                        out_idx_d = in_vidx;
                        out_val_d = in_value;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && in_cmd == CMD_START) begin
                    state_next = ST_A_OP;
                end else if (s_fire && in_cmd == CMD_TRACK) begin
                    state_next = ST_T_RD;
                end
            end
            ST_T_RD:  state_next = (t_reg == term_cnt_reg) ? ST_S_MUL : ST_T_LAT;
            ST_T_LAT: state_next = (ram_rdata.target == TGT_NONE) ? ST_T_RD : ST_T_POW;
            ST_T_POW: begin
                if (u_reg < cur_pow) begin
                    state_next = ST_T_MW;
                end else if (i_reg == 3'd5) begin
                    state_next = ST_T_ACC;
                end
            end
            ST_T_MW:  state_next = mul_done ? ST_T_POW : ST_T_MW;
            ST_T_ACC: state_next = ST_T_RD;
            ST_S_MUL: state_next = ST_S_MW;
            ST_S_MW: begin
                if (mul_done) begin
                    state_next = (j_reg == 2'd2) ? ST_S_SQ : ST_S_MUL;
                end
            end
            ST_S_SQ:  state_next = ST_S_SQW;
            ST_S_SQW: begin
                if (mul_done) begin
                    state_next = (i_reg == 3'd2) ? ST_S_CHK : ST_S_MUL;
                end
            end
            ST_S_CHK: state_next = div_req.start ? ST_S_RW : ST_COPY;
            ST_S_RW:  state_next = div_done ? ST_S_DIV : ST_S_RW;
            ST_S_DIV: state_next = ST_S_DW;
            ST_S_DW: begin
                if (div_done) begin
                    state_next = (i_reg == 3'd2) ? ST_COPY : ST_S_DIV;
                end
            end
            ST_COPY:  state_next = (k_reg == IDX_LASTV) ? ST_A_OP : ST_COPY;
            ST_A_OP:  state_next = ST_A_W;
            ST_A_W: begin
                if ((step_reg == 3'd1) ? div_done : mul_done) begin
                    state_next = (step_reg == 3'd4) ? ST_EMIT : ST_A_OP;
                end
            end
            ST_EMIT: begin
                if (out_free && k_reg == IDX_TIME) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            term_cnt_reg <= '0;
            turn_reg     <= '0;
            kom_reg      <= '0;
            ibc_reg      <= '0;
            rp_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            for (int v = 0; v < NUM_VARS; v++) begin
                var_reg[v] <= '0;
            end
        end else begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_KOM: kom_reg <= cfg_wdata;
                    CFG_IBC: ibc_reg <= cfg_wdata;
                    CFG_RP:  rp_reg  <= cfg_wdata;
                    default: ;
                endcase
            end

            // Table fill count
            if (s_fire && in_cmd == CMD_CLEAR) begin
                term_cnt_reg <= '0;
            end else if (ram_we) begin
                term_cnt_reg <= term_cnt_reg + TERM_CW'(1);
            end

            // Turn counter: restart, or advance at the end of a track
            if (s_fire && in_cmd == CMD_START) begin
                turn_reg <= '0;
            end else if (state_reg == ST_COPY && k_reg == IDX_LASTV && turn_reg != 16'hFFFF) begin
                turn_reg <= turn_reg + 16'd1;
            end

            if (var_we) begin
                var_reg[var_widx] <= var_wdata;
            end

            // Hold a result until taken
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_idx_reg  <= out_idx_d;
            out_val_reg  <= out_val_d;
            out_turn_reg <= turn_reg;
            out_err_reg  <= out_err_d;
            out_last_reg <= out_last_d;
        end

        unique case (state_reg)
            ST_IDLE: begin
                t_reg    <= '0;
                i_reg    <= 3'd0;
                j_reg    <= 2'd0;
                step_reg <= 3'd0;
                err_reg  <= 1'b0;
                if (s_fire && in_cmd == CMD_TRACK) begin
                    for (int s = 0; s < NUM_SUMS; s++) begin
                        acc_reg[s] <= '0;
                    end
                end
                so_acc_reg <= '0;
                sum_reg    <= '0;
            end
            ST_T_LAT: begin
                r_reg   <= ram_rdata.coef;
                pow_reg <= ram_rdata.powers;
                tg_reg  <= ram_rdata.target;
                i_reg   <= 3'd0;
                u_reg   <= 4'd0;
                if (ram_rdata.target == TGT_NONE) begin
                    t_reg <= t_reg + TERM_CW'(1);
                end
            end
            ST_T_POW: begin
                if (!(u_reg < cur_pow) && i_reg != 3'd5) begin
                    i_reg <= i_reg + 3'd1;
                    u_reg <= 4'd0;
                end
            end
            ST_T_MW: begin
                if (mul_done) begin
                    r_reg <= mul_res;
                    u_reg <= u_reg + 4'd1;
                end
            end
            ST_T_ACC: begin
                acc_reg[tg_reg] <= sadd(acc_rd, r_reg);
                t_reg           <= t_reg + TERM_CW'(1);
                i_reg           <= 3'd0;
            end
            ST_S_MW: begin
                if (mul_done) begin
                    so_acc_reg <= sadd(so_acc_reg, mul_res);
                    j_reg      <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
                end
            end
            ST_S_SQ: so_reg[i_reg[1:0]] <= so_acc_reg;
            ST_S_SQW: begin
                if (mul_done) begin
                    sum_reg    <= sadd(sum_reg, mul_res);
                    so_acc_reg <= '0;
                    i_reg      <= (i_reg == 3'd2) ? 3'd0 : i_reg + 3'd1;
                end
            end
            ST_S_CHK: begin
                k_reg <= 4'd0;
                if (!div_req.start) begin
                    err_reg <= 1'b1;
                    for (int c = 0; c < 3; c++) begin
                        so_reg[c] <= '0;
                    end
                end
            end
            ST_S_RW: begin
                if (div_done) begin
                    norm_reg <= div_res;
                end
            end
            ST_S_DW: begin
                if (div_done) begin
                    so_reg[i_reg[1:0]] <= div_res;
                    i_reg              <= i_reg + 3'd1;
                end
            end
            ST_COPY: k_reg <= k_reg + 4'd1;
            ST_A_W: begin
                // Collect each step of the arrival time
                if ((step_reg == 3'd1) ? div_done : mul_done) begin
                    step_reg <= step_reg + 3'd1;
                    k_reg    <= 4'd0;
                    case (step_reg)
                        3'd0: g_reg    <= sadd(mul_res, Q_ONE);
                        3'd1: lead_reg <= div_res;
                        3'd2: lead_reg <= mul_res;
                        3'd3: lead_reg <= sneg(mul_res);
                        default: time_reg <= sadd(lead_reg, mul_res);
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    k_reg <= k_reg + 4'd1;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, out_err_reg, out_turn_reg, out_val_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> sv/tmpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module tmpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/tmpt_mul.sv
// Sequential Q24.40 multiplier: four 32x32 partial products, sign fix-up,
// then round and saturate. Depends on tmpt_pkg.
module tmpt_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);
    import tmpt_pkg::*;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [2:0]   step_reg, step_next;
    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  res_reg, res_next;

    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [127:0] pp_wide;
    logic [127:0] rnd;

    // Partial product of the halves picked by the step
    always_comb begin
        a_half  = (step_reg == 3'd2 || step_reg == 3'd3) ? a_reg[63:32] : a_reg[31:0];
        b_half  = (step_reg == 3'd1 || step_reg == 3'd3) ? b_reg[63:32] : b_reg[31:0];
        pp      = 64'(a_half) * 64'(b_half);
        pp_wide = {64'd0, pp};
        if (step_reg == 3'd3) begin
            pp_wide = {pp, 64'd0};
        end else if (step_reg != 3'd0) begin
            pp_wide = {32'd0, pp, 32'd0};
        end
        rnd = acc_reg + Q_HALF_WIDE;
    end

    // Step sequence
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = 3'd0;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end else if (busy_reg) begin
            step_next = step_reg + 3'd1;
            case (step_reg)
                3'd4: begin
                    if (a_reg[63]) begin
                        acc_next = acc_reg - {b_reg, 64'd0};
                    end
                end
                3'd5: begin
                    if (b_reg[63]) begin
                        acc_next = acc_reg - {a_reg, 64'd0};
                    end
                end
                3'd6: begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    if (rnd[127:103] == {25{rnd[127]}}) begin
                        res_next = rnd[103:40];
                    end else begin
                        res_next = rnd[127] ? Q_MIN : Q_MAX;
                    end
                end
                default: begin
                    acc_next = acc_reg + pp_wide;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> sv/tmpt_div.sv
// Bit-serial unit for Q24.40 division (one quotient bit a cycle) and for the
// fixed-point square root (one root bit a cycle). Depends on tmpt_pkg.
module tmpt_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  tmpt_pkg::div_req_t  req,
    input  logic [63:0]         num,
    input  logic [63:0]         den,
    output logic                done,
    output logic [63:0]         result
);
    import tmpt_pkg::*;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [6:0]   cnt_reg, cnt_next;
    div_mode_t    mode_reg, mode_next;
    logic         neg_reg, neg_next;
    logic [63:0]  ud_reg, ud_next;
    logic [103:0] sh_reg, sh_next;
    logic [64:0]  rem_reg, rem_next;
    logic [103:0] quo_reg, quo_next;
    logic [63:0]  res_reg, res_next;

    logic [63:0]  un, ud;
    logic [64:0]  rem_sh, trial;
    logic         ge;
    logic [63:0]  lim;
    logic         ovf;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        neg_next  = neg_reg;
        ud_next   = ud_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        res_next  = res_reg;
        un        = num[63] ? (~num) + 64'd1 : num;
        ud        = den[63] ? (~den) + 64'd1 : den;
        rem_sh    = '0;
        trial     = '0;
        ge        = 1'b0;
        lim       = neg_reg ? Q_MIN : Q_MAX;
        ovf       = (quo_reg[103:64] != '0) || (quo_reg[63:0] > lim);

        if (req.start) begin
            // Load operands; divide by zero answers at once
            mode_next = req.mode;
            rem_next  = '0;
            quo_next  = '0;
            if (req.mode == DIV_QUOT && den == '0) begin
                done_next = 1'b1;
                res_next  = num[63] ? Q_MIN : Q_MAX;
            end else if (req.mode == DIV_QUOT) begin
                busy_next = 1'b1;
                cnt_next  = 7'd104;
                neg_next  = num[63] ^ den[63];
                ud_next   = ud;
                sh_next   = {un, 40'd0};
            end else begin
                busy_next = 1'b1;
                cnt_next  = 7'd52;
                sh_next   = {1'b0, num[62:0], 40'd0};
            end
        end else if (busy_reg && cnt_reg != 7'd0) begin
            // One restoring step
            cnt_next = cnt_reg - 7'd1;
            if (mode_reg == DIV_QUOT) begin
                rem_sh  = {rem_reg[63:0], sh_reg[103]};
                ge      = rem_sh >= {1'b0, ud_reg};
                rem_next = ge ? rem_sh - {1'b0, ud_reg} : rem_sh;
                sh_next = {sh_reg[102:0], 1'b0};
            end else begin
                rem_sh  = {rem_reg[62:0], sh_reg[103:102]};
                trial   = {quo_reg[62:0], 2'b01};
                ge      = rem_sh >= trial;
                rem_next = ge ? rem_sh - trial : rem_sh;
                sh_next = {sh_reg[101:0], 2'b00};
            end
            quo_next = {quo_reg[102:0], ge};
        end else if (busy_reg) begin
            // Sign, saturate and deliver
            busy_next = 1'b0;
            done_next = 1'b1;
            if (mode_reg == DIV_ROOT) begin
                res_next = quo_reg[63:0];
            end else if (ovf) begin
                res_next = neg_reg ? Q_MIN : Q_MAX;
            end else begin
                res_next = neg_reg ? (~quo_reg[63:0]) + 64'd1 : quo_reg[63:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mode_reg <= mode_next;
        neg_reg  <= neg_next;
        ud_reg   <= ud_next;
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> tb/sv/tb_taylor_map_particle_tracker.sv
// Testbench for taylor_map_particle_tracker: it drives command items, predicts every
// result with a local Q24.40 model of the term table and the tracking, and checks each one.
// Depends on tmpt_pkg and the taylor_map_particle_tracker RTL.
`timescale 1ns / 1ps

module tb_taylor_map_particle_tracker;
    import tmpt_pkg::*;

    typedef logic signed [63:0] q_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [3:0]  target;
        q_t          value;
        logic [23:0] powers;  // x lowest, four bits each
        logic [3:0]  var_index;
    } cmd_item_t;

    typedef struct {
        logic [3:0]  out_index;
        q_t          out_value;
        logic [15:0] turn_number;
        logic        error;
        logic        last;
    } track_result_t;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int SETTLE_CYCLES = 400;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [63:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;
    logic         m_tlast;

    taylor_map_particle_tracker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #4 aclk = ~aclk;

    // Shadow state of the tracker
    q_t          sh_coef [MAX_TERMS];
    logic [23:0] sh_pow  [MAX_TERMS];
    logic [3:0]  sh_tgt  [MAX_TERMS];
    int          sh_count;
    q_t          sh_vars [NUM_VARS];
    logic [15:0] sh_turn;
    q_t          kom_reg, ibc_reg, rp_reg;

    cmd_item_t     pending_cmds[$];
    track_result_t expected_results[$];
    int            mismatches;
    int            cycles;
    bit            idle_on;

    // Saturating Q24.40 arithmetic
    function automatic q_t q_add(q_t a, q_t b);
        logic signed [64:0] s;
        s = a + b;
        if (s[64] != s[63]) return s[64] ? q_t'(Q_MIN) : q_t'(Q_MAX);
        return s[63:0];
    endfunction

    function automatic q_t q_neg(q_t a);
        if (a == q_t'(Q_MIN)) return q_t'(Q_MAX);
        return -a;
    endfunction

    function automatic q_t q_mul(q_t a, q_t b);
        logic signed [127:0] p;
        p = a * b;
        p = p + (128'sd1 <<< 39);
        p = p >>> 40;
        if (p[127:63] != {65{p[127]}}) return p[127] ? q_t'(Q_MIN) : q_t'(Q_MAX);
        return p[63:0];
    endfunction

    function automatic q_t q_div(q_t n, q_t d);
        logic signed [127:0] nn, dd;
        logic [127:0] un, ud, qu, lim;
        logic neg;
        if (d == 0) return (n >= 0) ? q_t'(Q_MAX) : q_t'(Q_MIN);
        nn = n;
        dd = d;
        un = (nn < 0) ? -nn : nn;
        ud = (dd < 0) ? -dd : dd;
        neg = (n < 0) != (d < 0);
        qu = (un << 40) / ud;
        lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
        if (qu > lim) return neg ? q_t'(Q_MIN) : q_t'(Q_MAX);
        return neg ? -q_t'(qu[63:0]) : q_t'(qu[63:0]);
    endfunction

    // floor(sqrt(s * 2^40)) for a positive s
    function automatic q_t q_root(q_t s);
        logic [127:0] v, sq;
        logic [63:0] r, t;
        v = {64'd0, s} << 40;
        r = '0;
        for (int b = 51; b >= 0; b--) begin
            t = r | (64'd1 << b);
            sq = {64'd0, t} * {64'd0, t};
            if (sq <= v) r = t;
        end
        return r;
    endfunction

    function automatic q_t arrival_time();
        q_t g, ratio, lead, base;
        g = q_add(q_mul(q_add(q_t'(Q_ONE), sh_vars[5]), kom_reg), q_t'(Q_ONE));
        ratio = q_div(q_add(g, q_t'(Q_ONE)), g);
        lead = q_neg(q_mul(q_mul(ratio, ibc_reg), sh_vars[4]));
        base = q_mul(q_t'({48'd0, sh_turn}) <<< 40, rp_reg);
        return q_add(lead, base);
    endfunction

    task automatic push_result(logic [3:0] idx, q_t v, logic err, logic last);
        track_result_t r;
        r.out_index = idx;
        r.out_value = v;
        r.turn_number = sh_turn;
        r.error = err;
        r.last = last;
        expected_results.push_back(r);
    endtask

    task automatic push_particle(logic err);
        for (int i = 0; i < NUM_VARS; i++) push_result(4'(i), sh_vars[i], err, 1'b0);
        push_result(IDX_TIME, arrival_time(), err, 1'b1);
    endtask

    // One turn through the map, then renormalize the spin
    task automatic track_turn();
        q_t x [6];
        q_t sp [3];
        q_t acc [NUM_SUMS];
        q_t rot [3];
        q_t sum, r, nrm;
        logic err;
        for (int i = 0; i < 6; i++) x[i] = sh_vars[i];
        for (int i = 0; i < 3; i++) sp[i] = sh_vars[6 + i];
        for (int i = 0; i < NUM_SUMS; i++) acc[i] = '0;
        for (int t = 0; t < sh_count; t++) begin
            if (sh_tgt[t] == TGT_NONE) continue;
            r = sh_coef[t];
            for (int i = 0; i < 6; i++) begin
                for (int u = 0; u < int'(sh_pow[t][4*i +: 4]); u++) r = q_mul(r, x[i]);
            end
            acc[sh_tgt[t]] = q_add(acc[sh_tgt[t]], r);
        end
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            rot[i] = '0;
            for (int j = 0; j < 3; j++) rot[i] = q_add(rot[i], q_mul(acc[6 + 3*i + j], sp[j]));
            sum = q_add(sum, q_mul(rot[i], rot[i]));
        end
        err = 1'b0;
        if (sum <= 0) begin
            err = 1'b1;
            for (int i = 0; i < 3; i++) sh_vars[6 + i] = '0;
        end else begin
            nrm = q_root(sum);
            for (int i = 0; i < 3; i++) sh_vars[6 + i] = q_div(rot[i], nrm);
        end
        for (int i = 0; i < 6; i++) sh_vars[i] = acc[i];
        if (sh_turn != 16'hFFFF) sh_turn = sh_turn + 16'd1;
        push_particle(err);
    endtask

    // Update the shadow state for one accepted item and queue its results
    task automatic predict_command(cmd_item_t c);
        case (c.cmd)
            CMD_CLEAR: begin
                sh_count = 0;
                push_result(4'd0, '0, 1'b0, 1'b1);
            end
            CMD_APPEND: begin
                if (sh_count >= MAX_TERMS) begin
                    push_result(4'd0, '0, 1'b1, 1'b1);
                end else begin
                    sh_coef[sh_count] = c.value;
                    sh_pow[sh_count] = c.powers;
                    sh_tgt[sh_count] = c.target;
                    sh_count++;
                    push_result(4'd0, '0, 1'b0, 1'b1);
                end
            end
            CMD_WRITE: begin
                if (c.var_index < NUM_VARS) begin
                    sh_vars[c.var_index] = c.value;
                    push_result(c.var_index, c.value, 1'b0, 1'b1);
                end else begin
                    push_result(4'd0, '0, 1'b0, 1'b1);
                end
            end
            CMD_START: begin
                sh_turn = '0;
                push_particle(1'b0);
            end
            CMD_TRACK: track_turn();
            default: ;
        endcase
    endtask

    // Driver: feed pending items, with random idle bursts
    cmd_item_t cur_cmd;
    int        send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_command(cur_cmd);
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tdata <= {5'd0, cur_cmd.var_index, cur_cmd.powers, cur_cmd.value,
                                cur_cmd.target, cur_cmd.cmd};
                    s_tvalid <= 1'b1;
                    if (idle_on && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 19);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest expectation, stall at random
    int stall_left = 0;
    always @(posedge aclk) begin
        track_result_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation: %h", m_tdata);
                    mismatches++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tdata[3:0] !== e.out_index) begin
                        $error("out_index expected %0d got %0d", e.out_index, m_tdata[3:0]);
                        mismatches++;
                    end
                    if (m_tdata[67:4] !== e.out_value) begin
                        $error("out_value expected %h got %h", e.out_value, m_tdata[67:4]);
                        mismatches++;
                    end
                    if (m_tdata[83:68] !== e.turn_number) begin
                        $error("turn_number expected %0d got %0d", e.turn_number,
                               m_tdata[83:68]);
                        mismatches++;
                    end
                    if (m_tdata[84] !== e.error) begin
                        $error("error expected %0b got %0b", e.error, m_tdata[84]);
                        mismatches++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last expected %0b got %0b", e.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 18);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic q_t rand_q();
        logic [63:0] raw;
        int sel;
        raw = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel < 6) return q_t'({{22{raw[41]}}, raw[41:0]});
        if (sel < 8) return q_t'(raw);
        if (sel == 8) return raw[0] ? q_t'(Q_ONE) : -q_t'(Q_ONE);
        case (raw[1:0])
            2'd0: return '0;
            2'd1: return q_t'(Q_MAX);
            default: return q_t'(Q_MIN);
        endcase
    endfunction

    function automatic cmd_item_t make_cmd(logic [2:0] cmd, logic [3:0] tgt, q_t v,
                                          logic [23:0] pw, logic [3:0] vi);
        cmd_item_t c;
        c.cmd = cmd;
        c.target = tgt;
        c.value = v;
        c.powers = pw;
        c.var_index = vi;
        return c;
    endfunction

    // Mostly low exponents keep a turn short; now and then the full range
    function automatic logic [23:0] rand_powers();
        logic [23:0] pw;
        bit wide;
        wide = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < 6; i++) pw[4*i +: 4] = wide ? 4'($urandom) : 4'($urandom_range(0, 2));
        return pw;
    endfunction

    task automatic cfg_write(logic [1:0] idx, q_t v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            CFG_KOM: kom_reg = v;
            CFG_IBC: ibc_reg = v;
            default: rp_reg = v;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(q_t kom, q_t ibc, q_t rp);
        cfg_write(CFG_KOM, kom);
        cfg_write(CFG_IBC, ibc);
        cfg_write(CFG_RP, rp);
    endtask

    // Wait for every item to be taken and every result to arrive, then settle
    task automatic drain();
        while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One well-formed particle run with random content, with some noise
    task automatic queue_random_run(ref int n);
        int terms;
        logic [3:0] vi;
        pending_cmds.push_back(make_cmd(CMD_CLEAR, 4'($urandom), rand_q(), 24'($urandom), 4'($urandom)));
        terms = $urandom_range(1, 8);
        for (int k = 0; k < terms; k++) begin
            pending_cmds.push_back(make_cmd(CMD_APPEND,
                ($urandom_range(0, 9) == 0) ? TGT_NONE : 4'($urandom_range(0, 14)),
                rand_q(), rand_powers(), 4'($urandom)));
        end
        for (int k = 0; k < NUM_VARS; k++) begin
            vi = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'(k);
            pending_cmds.push_back(make_cmd(CMD_WRITE, 4'($urandom), rand_q(), 24'($urandom), vi));
        end
        if ($urandom_range(0, 4) == 0)
            pending_cmds.push_back(make_cmd(CMD_TRACK + 3'($urandom_range(1, 3)), 4'($urandom),
                                            rand_q(), 24'($urandom), 4'($urandom)));
        pending_cmds.push_back(make_cmd(CMD_START, 4'($urandom), rand_q(), 24'($urandom),
                                        4'($urandom)));
        terms = $urandom_range(1, 4);
        for (int k = 0; k < terms; k++)
            pending_cmds.push_back(make_cmd(CMD_TRACK, 4'($urandom), rand_q(), 24'($urandom),
                                            4'($urandom)));
        n += 2 + terms + NUM_VARS + $urandom_range(1, 8);
    endtask

    // Queue runs until about the given number of items; idling only when allowed
    task automatic random_phase(int target_items, bit idle_ok);
        int n;
        n = 0;
        while (n < target_items) begin
            idle_on = idle_ok && ($urandom_range(0, 3) != 0);
            queue_random_run(n);
        end
    endtask

    localparam logic [23:0] PW_X1 = 24'h000001;

    initial begin
        sh_count = 0;
        sh_turn = '0;
        for (int i = 0; i < NUM_VARS; i++) sh_vars[i] = '0;
        kom_reg = '0;
        ibc_reg = '0;
        rp_reg = '0;
        mismatches = 0;
        cycles = 0;
        idle_on = 1'b1;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        set_config('0, '0, '0);

        // Directed: identity map, extremes, bad variables, unknown codes, zero spin
        pending_cmds.push_back(make_cmd(CMD_CLEAR, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_APPEND, 4'd0, q_t'(Q_ONE), PW_X1, '0));
        pending_cmds.push_back(make_cmd(CMD_APPEND, 4'd6, q_t'(Q_ONE), '0, '0));
        pending_cmds.push_back(make_cmd(CMD_APPEND, 4'd10, q_t'(Q_ONE), '0, '0));
        pending_cmds.push_back(make_cmd(CMD_APPEND, 4'd14, q_t'(Q_ONE), '0, '0));
        pending_cmds.push_back(make_cmd(CMD_APPEND, TGT_NONE, q_t'(Q_MAX), 24'hFFFFFF, 4'hF));
        pending_cmds.push_back(make_cmd(CMD_APPEND, 4'd4, q_t'(Q_MIN), '0, '0));
        pending_cmds.push_back(make_cmd(CMD_APPEND, 4'd1, q_t'(Q_ONE), 24'h00000F, '0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, '0, q_t'(Q_ONE) >>> 1, '0, 4'd0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, '0, q_t'(Q_ONE), '0, 4'd6));
        pending_cmds.push_back(make_cmd(CMD_WRITE, '0, q_t'(Q_MAX), '0, 4'd4));
        pending_cmds.push_back(make_cmd(CMD_WRITE, '0, q_t'(Q_MIN), '0, IDX_LASTV));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 4'hF, q_t'(Q_MAX), 24'hFFFFFF, 4'd9));
        pending_cmds.push_back(make_cmd(CMD_WRITE, '0, q_t'(Q_MIN), '0, 4'hF));
        for (int k = 1; k <= 3; k++)
            pending_cmds.push_back(make_cmd(CMD_TRACK + 3'(k), '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_START, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_TRACK, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_TRACK, '0, '0, '0, '0));
        for (int k = 6; k <= 8; k++)
            pending_cmds.push_back(make_cmd(CMD_WRITE, '0, '0, '0, 4'(k)));
        pending_cmds.push_back(make_cmd(CMD_TRACK, '0, '0, '0, '0));
        drain();

        // Extremes of every configuration register
        set_config(q_t'(Q_MAX), q_t'(Q_MIN), q_t'(Q_MAX));
        random_phase(30, 1'b1);
        drain();

        // g of zero: arrival time divides by zero
        set_config(-q_t'(Q_ONE), q_t'(Q_ONE), q_t'(Q_MIN));
        pending_cmds.push_back(make_cmd(CMD_WRITE, '0, '0, '0, 4'd5));
        pending_cmds.push_back(make_cmd(CMD_WRITE, '0, q_t'(Q_ONE), '0, 4'd4));
        pending_cmds.push_back(make_cmd(CMD_START, '0, '0, '0, '0));
        random_phase(30, 1'b1);
        drain();

        // Typical beam settings
        set_config(rand_q(), rand_q(), rand_q());
        random_phase(60, 1'b1);
        drain();

        // Last part: no idling on either side
        set_config(q_t'({$urandom, $urandom}), q_t'(Q_ONE) <<< 2, q_t'(Q_ONE) >>> 3);
        random_phase(40, 1'b0);
        idle_on = 1'b0;
        drain();

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
